### sv/boundary_tag_first_fit_allocator_unit_macros.svh
// Assertion macros for the checker file, btffa_checker.sv.
`ifndef BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_UNIT_MACROS_SVH
`define BOUNDARY_TAG_FIRST_FIT_ALLOCATOR_UNIT_MACROS_SVH

// Clocked assertion, quiet while reset is active.
`define BTFFA_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("btffa assertion failed");

// Implication checked against the same clock and reset.
`define BTFFA_ASSERT_IMP(label, pre, post) \
  `BTFFA_ASSERT(label, (pre) |-> (post))

`endif

### sv/btffa_pkg.sv
package btffa_pkg;

  localparam int unsigned HEAP_WORDS_DEF  = 1024;
  localparam int unsigned MIN_BLOCK_WORDS = 3;
  localparam int unsigned REQ_W           = 13;
  localparam int unsigned NEED_W          = 11;
  localparam int unsigned TGT_W           = 10;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [REQ_W-1:0] request_bytes;
    logic [REQ_W-1:0] free_addr;
  } in_item_t;

  typedef struct packed {
    logic [REQ_W-1:0] payload_addr;
    logic             ok;
  } out_item_t;

endpackage

### sv/btffa_ram.sv
module btffa_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/boundary_tag_first_fit_allocator_unit.sv
// Allocate: walk over the blocks to the first fit, then 2 or 4 tag writes (none on failure),
//   then load the result register; the tag memory's one port sets the pace, one block per cycle.
// Free: walk to the block, read the right neighbor unless it is the last, merge, 2 writes.
// One item at a time; a new item is taken while the previous result waits.
// After reset the block writes the header and footer of the initial free block (S_INIT0, S_INIT1);
// the heap break (reset 3 words) bounds every read whose data is used, so older words are never seen.
module boundary_tag_first_fit_allocator_unit #(
  parameter int unsigned HEAP_WORDS = btffa_pkg::HEAP_WORDS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  btffa_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output btffa_pkg::out_item_t out_item_o
);

  localparam int unsigned AW = $clog2(HEAP_WORDS);
  localparam int unsigned BW = $clog2(HEAP_WORDS + 1);
  localparam int unsigned TW = BW + 1;
  localparam int unsigned SW = (BW > btffa_pkg::NEED_W) ? BW : btffa_pkg::NEED_W;
  localparam int unsigned EW = SW + 1;
  localparam int unsigned RW = btffa_pkg::REQ_W;

  typedef enum logic [3:0] {
    S_INIT0, S_INIT1, S_IDLE, S_WALK, S_NEXT, S_MERGE, S_WR_HDR, S_WR_FTR, S_RESP
  } state_e;

  state_e           state_q, state_d;
  logic [BW-1:0]    pos_q, pos_d, brk_q, brk_d, prev_q, prev_d, sz_q, sz_d;
  logic [BW-1:0]    total_q, total_d;
  logic [SW-1:0]    need_q, need_d;
  logic [btffa_pkg::TGT_W-1:0] tgt_q, tgt_d;
  logic             cmd_q, cmd_d, have_prev_q, have_prev_d, prev_free_q, prev_free_d;
  logic [AW-1:0]    wr_at_q, wr_at_d, sec_at_q, sec_at_d;
  logic [BW-1:0]    wr_words_q, wr_words_d, sec_words_q, sec_words_d;
  logic             wr_used_q, wr_used_d, sec_pend_q, sec_pend_d;
  logic [RW-1:0]    res_addr_q, res_addr_d;
  logic             res_ok_q, res_ok_d;
  logic             out_valid_q, out_valid_d;
  btffa_pkg::out_item_t out_item_q, out_item_d;

  logic             mem_we;
  logic [AW-1:0]    mem_addr;
  logic [TW-1:0]    mem_wdata, mem_rdata;

  logic [EW-1:0]    pos_x, brk_x, need_x, rsz_x, end_x, tgt_x, heap_x, nxt_x, app_x;
  logic [EW+2:0]    pa_pos, pa_brk;
  logic             rused, bad;
  logic [RW:0]      req_sum;

  btffa_ram #(.WIDTH(TW), .DEPTH(HEAP_WORDS)) u_tags (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  assign rused  = mem_rdata[0];
  assign rsz_x  = EW'(mem_rdata[TW-1:1]);
  assign pos_x  = EW'(pos_q);
  assign brk_x  = EW'(brk_q);
  assign need_x = EW'(need_q);
  assign tgt_x  = EW'(tgt_q);
  assign heap_x = EW'(HEAP_WORDS);
  assign end_x  = pos_x + rsz_x;
  assign nxt_x  = pos_x + EW'(sz_q);
  assign app_x  = brk_x + need_x;
  assign bad    = (rsz_x == '0) || (end_x > brk_x);
  assign pa_pos = {pos_x, 3'b000} + (EW+3)'(8);
  assign pa_brk = {brk_x, 3'b000} + (EW+3)'(8);
  assign req_sum = {1'b0, in_item_i.request_bytes} + (RW+1)'(23);

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    brk_d       = brk_q;
    prev_d      = prev_q;
    sz_d        = sz_q;
    total_d     = total_q;
    need_d      = need_q;
    tgt_d       = tgt_q;
    cmd_d       = cmd_q;
    have_prev_d = have_prev_q;
    prev_free_d = prev_free_q;
    wr_at_d     = wr_at_q;
    wr_words_d  = wr_words_q;
    wr_used_d   = wr_used_q;
    sec_at_d    = sec_at_q;
    sec_words_d = sec_words_q;
    sec_pend_d  = sec_pend_q;
    res_addr_d  = res_addr_q;
    res_ok_d    = res_ok_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    mem_we      = 1'b0;
    mem_addr    = pos_q[AW-1:0];
    mem_wdata   = {wr_words_q, wr_used_q};

    unique case (state_q)
      S_INIT0: begin
        mem_we    = 1'b1;
        mem_addr  = '0;
        mem_wdata = {BW'(btffa_pkg::MIN_BLOCK_WORDS), 1'b0};
        state_d   = S_INIT1;
      end
      S_INIT1: begin
        mem_we    = 1'b1;
        mem_addr  = AW'(btffa_pkg::MIN_BLOCK_WORDS - 1);
        mem_wdata = {BW'(btffa_pkg::MIN_BLOCK_WORDS), 1'b0};
        state_d   = S_IDLE;
      end
      S_IDLE: begin
        mem_addr = '0;
        if (in_valid_i) begin
          cmd_d       = in_item_i.cmd;
          pos_d       = '0;
          have_prev_d = 1'b0;
          prev_free_d = 1'b0;
          sec_pend_d  = 1'b0;
          need_d      = SW'(req_sum[RW:3]);
          tgt_d       = in_item_i.free_addr[RW-1:3] - btffa_pkg::TGT_W'(1);
          if (in_item_i.cmd == btffa_pkg::CMD_FREE &&
              (in_item_i.free_addr < RW'(8) || in_item_i.free_addr[2:0] != 3'b000)) begin
            res_addr_d = '0;
            res_ok_d   = 1'b0;
            state_d    = S_RESP;
          end else begin
            state_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        mem_addr = end_x[AW-1:0];
        if (cmd_q == btffa_pkg::CMD_ALLOC) begin
          if (!bad && !rused && rsz_x >= need_x) begin
            wr_at_d    = pos_q[AW-1:0];
            wr_used_d  = 1'b1;
            res_addr_d = pa_pos[RW-1:0];
            res_ok_d   = 1'b1;
            state_d    = S_WR_HDR;
            if (rsz_x - need_x >= EW'(btffa_pkg::MIN_BLOCK_WORDS)) begin
              wr_words_d  = BW'(need_x);
              sec_at_d    = AW'(pos_x + need_x);
              sec_words_d = BW'(rsz_x - need_x);
              sec_pend_d  = 1'b1;
            end else begin
              wr_words_d = BW'(rsz_x);
            end
          end else if (!bad && end_x < brk_x) begin
            pos_d = BW'(end_x);
          end else if (app_x > heap_x) begin
            res_addr_d = '0;
            res_ok_d   = 1'b0;
            state_d    = S_RESP;
          end else begin
            wr_at_d    = brk_q[AW-1:0];
            wr_words_d = BW'(need_x);
            wr_used_d  = 1'b1;
            brk_d      = BW'(app_x);
            res_addr_d = pa_brk[RW-1:0];
            res_ok_d   = 1'b1;
            state_d    = S_WR_HDR;
          end
        end else begin
          res_addr_d = '0;
          res_ok_d   = 1'b0;
          if (bad || pos_x > tgt_x) begin
            state_d = S_RESP;
          end else if (pos_x == tgt_x) begin
            sz_d    = BW'(rsz_x);
            total_d = BW'(rsz_x);
            if (!rused) begin
              state_d = S_RESP;
            end else if (end_x < brk_x) begin
              state_d = S_NEXT;
            end else begin
              state_d = S_MERGE;
            end
          end else begin
            prev_d      = pos_q;
            prev_free_d = !rused;
            have_prev_d = 1'b1;
            if (end_x < brk_x) begin
              pos_d = BW'(end_x);
            end else begin
              state_d = S_RESP;
            end
          end
        end
      end
      S_NEXT: begin
        // mem_rdata holds the right neighbor's header
        if (!rused && rsz_x != '0 && nxt_x + rsz_x <= brk_x) begin
          total_d = BW'(EW'(sz_q) + rsz_x);
        end
        state_d = S_MERGE;
      end
      S_MERGE: begin
        wr_used_d = 1'b0;
        res_ok_d  = 1'b1;
        if (have_prev_q && prev_free_q) begin
          wr_at_d    = prev_q[AW-1:0];
          wr_words_d = total_q + (pos_q - prev_q);
        end else begin
          wr_at_d    = pos_q[AW-1:0];
          wr_words_d = total_q;
        end
        state_d = S_WR_HDR;
      end
      S_WR_HDR: begin
        mem_we   = 1'b1;
        mem_addr = wr_at_q;
        state_d  = S_WR_FTR;
      end
      S_WR_FTR: begin
        mem_we   = 1'b1;
        mem_addr = AW'(EW'(wr_at_q) + EW'(wr_words_q) - EW'(1));
        if (sec_pend_q) begin
          wr_at_d    = sec_at_q;
          wr_words_d = sec_words_q;
          wr_used_d  = 1'b0;
          sec_pend_d = 1'b0;
          state_d    = S_WR_HDR;
        end else begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d             = 1'b1;
          out_item_d.payload_addr = res_addr_q;
          out_item_d.ok           = res_ok_q;
          state_d                 = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT0;
      brk_q       <= BW'(btffa_pkg::MIN_BLOCK_WORDS);
      out_valid_q <= 1'b0;
      sec_pend_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      brk_q       <= brk_d;
      out_valid_q <= out_valid_d;
      sec_pend_q  <= sec_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    prev_q      <= prev_d;
    sz_q        <= sz_d;
    total_q     <= total_d;
    need_q      <= need_d;
    tgt_q       <= tgt_d;
    cmd_q       <= cmd_d;
    have_prev_q <= have_prev_d;
    prev_free_q <= prev_free_d;
    wr_at_q     <= wr_at_d;
    wr_words_q  <= wr_words_d;
    wr_used_q   <= wr_used_d;
    sec_at_q    <= sec_at_d;
    sec_words_q <= sec_words_d;
    res_addr_q  <= res_addr_d;
    res_ok_q    <= res_ok_d;
    out_item_q  <= out_item_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### sv/btffa_checker.sv
`include "boundary_tag_first_fit_allocator_unit_macros.svh"

module btffa_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input btffa_pkg::out_item_t out_item_o
);

  `BTFFA_ASSERT_IMP(a_out_hold, out_valid_o && !out_ready_i, ##1 out_valid_o)
  `BTFFA_ASSERT_IMP(a_fail_zero, out_valid_o && !out_item_o.ok, out_item_o.payload_addr == '0)
  `BTFFA_ASSERT_IMP(a_addr_align, out_valid_o, out_item_o.payload_addr[2:0] == 3'b000)
  `BTFFA_ASSERT_IMP(a_busy_after_accept, in_valid_i && in_ready_o, ##1 !in_ready_o)

endmodule

bind boundary_tag_first_fit_allocator_unit btffa_checker u_btffa_checker (.*);
